// ----- hw/rtl/gctp_pkg.sv -----
// Shared types and constants for the geo coordinate text parser.
// No dependencies; used by geo_coordinate_text_parser.
package gctp_pkg;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DEG_W    = 8;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned WEIGHT_W = 20;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FORMAT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MINUTES = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LAT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LON     = 3'd4;

  localparam logic [COORD_W-1:0] UNITS_PER_DEGREE = 32'd6000000;
  localparam logic [11:0]        LIMIT_LAT        = 12'd90;
  localparam logic [11:0]        LIMIT_LON        = 12'd180;
  localparam logic [CNT_W-1:0]   DEC_DIGITS       = 3'd6;
  localparam logic [CNT_W-1:0]   DEC_COUNT_MAX    = 3'd7;
  localparam logic [CNT_W-1:0]   MIN_DIGITS       = 3'd2;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c;
  localparam logic [CHAR_W-1:0] CH_N_UP   = 8'h4e;
  localparam logic [CHAR_W-1:0] CH_N_LO   = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_S_UP   = 8'h53;
  localparam logic [CHAR_W-1:0] CH_S_LO   = 8'h73;
  localparam logic [CHAR_W-1:0] CH_E_UP   = 8'h45;
  localparam logic [CHAR_W-1:0] CH_E_LO   = 8'h65;
  localparam logic [CHAR_W-1:0] CH_W_UP   = 8'h57;
  localparam logic [CHAR_W-1:0] CH_W_LO   = 8'h77;

  typedef struct packed {
    logic point;
    logic letter;
    logic digit;
    logic sign;
  } seen_t;

  // weight of a fraction digit by position, in 1/6000000 degree
  function automatic logic [WEIGHT_W-1:0] digit_weight(input logic minutes,
                                                       input logic [CNT_W-1:0] pos);
    logic [WEIGHT_W-1:0] w;
    w = '0;
    if (minutes) begin
      case (pos)
        3'd0:    w = 20'd1000000;
        3'd1:    w = 20'd100000;
        default: w = '0;
      endcase
    end else begin
      case (pos)
        3'd0:    w = 20'd600000;
        3'd1:    w = 20'd60000;
        3'd2:    w = 20'd6000;
        3'd3:    w = 20'd600;
        3'd4:    w = 20'd60;
        3'd5:    w = 20'd6;
        default: w = '0;
      endcase
    end
    return w;
  endfunction

endpackage

// ----- hw/rtl/geo_coordinate_text_parser.sv -----
// Top level of the geo coordinate text parser: input register, parse step, result register.
// Depends on gctp_pkg.
//
//  channel | dir | tdata                  | tuser
//  in_     | in  | [7:0] character        | [0] action (1 = end), [1] is_longitude
//  out_    | out | [31:0] coordinate      | [2:0] status
//
// One character per cycle while the input register is not stalled. Each word goes
// through the input register, then the parse logic updates the state; an end word
// loads the result register. The input register stalls only while an end word
// waits for a full result register. rst_n is synchronous and clears all control
// and parse state.
module geo_coordinate_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic [1:0]  in_tuser,   // [0] action, [1] is_longitude
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] coordinate
  output logic [2:0]  out_tuser   // [2:0] status
);

  // input register
  logic                           s1_valid_r;
  logic [gctp_pkg::CHAR_W-1:0]    s1_char_r;
  logic                           s1_end_r;
  logic                           s1_lon_r;

  // parse state
  logic [gctp_pkg::DEG_W-1:0]     deg_r,   deg_nxt;
  logic [gctp_pkg::FRAC_W-1:0]    frac_r,  frac_nxt;
  logic [gctp_pkg::CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic                           in_frac_r, in_frac_nxt;
  logic                           min_mode_r, min_mode_nxt;
  gctp_pkg::seen_t                seen_r,  seen_nxt;
  logic                           neg_r,   neg_nxt;
  logic [gctp_pkg::STATUS_W-1:0]  err_r,   err_nxt;

  // result register
  logic                           out_valid_r;
  logic [gctp_pkg::STATUS_W-1:0]  out_status_r;
  logic [gctp_pkg::COORD_W-1:0]   out_coord_r, out_coord_nxt;

  logic                           adv;
  logic [3:0]                     digit;
  logic [11:0]                    deg_try;
  logic [11:0]                    limit;
  logic [gctp_pkg::FRAC_W-1:0]    frac_add;
  logic [gctp_pkg::COORD_W-1:0]   total;

  function automatic logic [gctp_pkg::FRAC_W-1:0] FRAC_W_CAST(
      input logic [3:0] d, input logic [gctp_pkg::WEIGHT_W-1:0] w);
    return {4'd0, w} * {20'd0, d};
  endfunction

  assign adv       = s1_valid_r && (!s1_end_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  assign digit    = s1_char_r[3:0];
  assign deg_try  = {4'd0, deg_r} * 12'd10 + {8'd0, digit};
  assign limit    = s1_lon_r ? gctp_pkg::LIMIT_LON : gctp_pkg::LIMIT_LAT;
  assign frac_add = FRAC_W_CAST(digit, gctp_pkg::digit_weight(min_mode_r, cnt_r));
  assign total    = {24'd0, deg_r} * gctp_pkg::UNITS_PER_DEGREE + {8'd0, frac_r};

  always_comb begin
    deg_nxt       = deg_r;
    frac_nxt      = frac_r;
    cnt_nxt       = cnt_r;
    in_frac_nxt   = in_frac_r;
    min_mode_nxt  = min_mode_r;
    seen_nxt      = seen_r;
    neg_nxt       = neg_r;
    err_nxt       = err_r;
    out_coord_nxt = '0;
    if (err_r == gctp_pkg::ST_OK) begin
      out_coord_nxt = neg_r ? (32'd0 - total) : total;
    end

    if (adv) begin
      if (s1_end_r) begin
        deg_nxt      = '0;
        frac_nxt     = '0;
        cnt_nxt      = '0;
        in_frac_nxt  = 1'b0;
        min_mode_nxt = 1'b0;
        seen_nxt     = '0;
        neg_nxt      = 1'b0;
        err_nxt      = gctp_pkg::ST_OK;
      end else if (err_r == gctp_pkg::ST_OK) begin
        if (s1_char_r inside {[gctp_pkg::CH_0:gctp_pkg::CH_9]}) begin
          seen_nxt.digit = 1'b1;
          if (in_frac_r) begin
            if (min_mode_r) begin
              if (cnt_r >= gctp_pkg::MIN_DIGITS) begin
                err_nxt = gctp_pkg::ST_MINUTES;
              end else begin
                frac_nxt = frac_r + frac_add;
                cnt_nxt  = cnt_r + 3'd1;
              end
            end else begin
              if (cnt_r < gctp_pkg::DEC_DIGITS) begin
                frac_nxt = frac_r + frac_add;
              end
              if (cnt_r < gctp_pkg::DEC_COUNT_MAX) begin
                cnt_nxt = cnt_r + 3'd1;
              end
            end
          end else if (deg_try > limit) begin
            err_nxt = s1_lon_r ? gctp_pkg::ST_LON : gctp_pkg::ST_LAT;
          end else begin
            deg_nxt = deg_try[gctp_pkg::DEG_W-1:0];
          end
        end else begin
          case (s1_char_r)
            gctp_pkg::CH_N_UP, gctp_pkg::CH_N_LO,
            gctp_pkg::CH_S_UP, gctp_pkg::CH_S_LO,
            gctp_pkg::CH_E_UP, gctp_pkg::CH_E_LO,
            gctp_pkg::CH_W_UP, gctp_pkg::CH_W_LO: begin
              // the low five bits of a letter code are the same in both cases
              if (seen_r.letter || seen_r.sign || seen_r.point) begin
                err_nxt = gctp_pkg::ST_FORMAT;
              end else if ((s1_char_r[4:0] == gctp_pkg::CH_E_UP[4:0] ||
                            s1_char_r[4:0] == gctp_pkg::CH_W_UP[4:0]) != s1_lon_r) begin
                err_nxt = gctp_pkg::ST_FORMAT;
              end else begin
                seen_nxt.letter = 1'b1;
                in_frac_nxt     = 1'b1;
                min_mode_nxt    = 1'b1;
                neg_nxt         = (s1_char_r[4:0] == gctp_pkg::CH_S_UP[4:0]) ||
                                  (s1_char_r[4:0] == gctp_pkg::CH_W_UP[4:0]);
              end
            end
            gctp_pkg::CH_PLUS, gctp_pkg::CH_MINUS: begin
              if (seen_r.letter || seen_r.digit || seen_r.point) begin
                err_nxt = gctp_pkg::ST_FORMAT;
              end else begin
                seen_nxt.sign = 1'b1;
                neg_nxt       = (s1_char_r == gctp_pkg::CH_MINUS);
              end
            end
            gctp_pkg::CH_POINT, gctp_pkg::CH_COMMA: begin
              if (seen_r.letter || seen_r.point) begin
                err_nxt = gctp_pkg::ST_FORMAT;
              end else begin
                seen_nxt.point = 1'b1;
                in_frac_nxt    = 1'b1;
                min_mode_nxt   = 1'b0;
              end
            end
            default: begin
              err_nxt = gctp_pkg::ST_FORMAT;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      deg_r       <= '0;
      frac_r      <= '0;
      cnt_r       <= '0;
      in_frac_r   <= 1'b0;
      min_mode_r  <= 1'b0;
      seen_r      <= '0;
      neg_r       <= 1'b0;
      err_r       <= gctp_pkg::ST_OK;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv && s1_end_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      deg_r      <= deg_nxt;
      frac_r     <= frac_nxt;
      cnt_r      <= cnt_nxt;
      in_frac_r  <= in_frac_nxt;
      min_mode_r <= min_mode_nxt;
      seen_r     <= seen_nxt;
      neg_r      <= neg_nxt;
      err_r      <= err_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_end_r  <= in_tuser[0];
      s1_lon_r  <= in_tuser[1];
    end
    if (adv && s1_end_r) begin
      out_status_r <= err_r;
      out_coord_r  <= out_coord_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_coord_r;
  assign out_tuser  = out_status_r;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for geo_coordinate_text_parser: directed and random coordinate text,
// a local predictor of status and fixed-point value, random stalls on both streams.
// Depends on gctp_pkg and the parser RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int WORD_TARGET = 600;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    logic                        action;
    logic [gctp_pkg::CHAR_W-1:0] ch;
    logic                        lon;
    bit                          drain;   // sender waits for all results before this word
  } text_word_t;

  typedef struct {
    logic [gctp_pkg::STATUS_W-1:0] status;
    logic [gctp_pkg::COORD_W-1:0]  coord;
  } coord_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  geo_coordinate_text_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  text_word_t    word_q[$];
  coord_result_t coord_q[$];
  logic [7:0]    text_buf[$];
  bit            drain_next = 0;
  int            words_total = 0;
  int            words_taken = 0;
  int            results_seen = 0;
  int            fail_count = 0;
  int            status_count[5] = '{0, 0, 0, 0, 0};
  int            lo_coord = 0;
  int            hi_coord = 0;

  // parser state as the predictor sees it
  logic [gctp_pkg::DEG_W-1:0]    deg = '0;
  logic [gctp_pkg::FRAC_W-1:0]   frac = '0;
  logic [gctp_pkg::CNT_W-1:0]    fcnt = '0;
  logic                          in_frac = 1'b0;
  logic                          min_mode = 1'b0;
  gctp_pkg::seen_t               seen = '0;
  logic                          neg = 1'b0;
  logic [gctp_pkg::STATUS_W-1:0] err = gctp_pkg::ST_OK;

  logic [19:0] dec_wt[6] = '{20'd600000, 20'd60000, 20'd6000, 20'd600, 20'd60, 20'd6};
  logic [19:0] min_wt[2] = '{20'd1000000, 20'd100000};

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  task automatic clear_parse();
    deg = '0; frac = '0; fcnt = '0; in_frac = 1'b0; min_mode = 1'b0;
    seen = '0; neg = 1'b0; err = gctp_pkg::ST_OK;
  endtask

  task automatic take_digit(input logic [3:0] d, input logic lon);
    logic [11:0] t;
    seen.digit = 1'b1;
    if (in_frac) begin
      if (min_mode) begin
        if (fcnt >= gctp_pkg::MIN_DIGITS) begin
          err = gctp_pkg::ST_MINUTES;
          return;
        end
        frac = frac + d * min_wt[fcnt];
        fcnt = fcnt + 1'b1;
      end else begin
        if (fcnt < gctp_pkg::DEC_DIGITS) frac = frac + d * dec_wt[fcnt];
        if (fcnt < gctp_pkg::DEC_COUNT_MAX) fcnt = fcnt + 1'b1;
      end
    end else begin
      t = {4'd0, deg} * 12'd10 + {8'd0, d};
      if (t > (lon ? gctp_pkg::LIMIT_LON : gctp_pkg::LIMIT_LAT))
        err = lon ? gctp_pkg::ST_LON : gctp_pkg::ST_LAT;
      else deg = t[gctp_pkg::DEG_W-1:0];
    end
  endtask

  task automatic take_letter(input logic axis_lon, input logic south_west, input logic lon);
    if (seen.letter || seen.sign || seen.point || axis_lon != lon) begin
      err = gctp_pkg::ST_FORMAT;
      return;
    end
    seen.letter = 1'b1;
    in_frac = 1'b1;
    min_mode = 1'b1;
    neg = south_west;
  endtask

  task automatic parse_word(input logic action, input logic [7:0] ch, input logic lon);
    coord_result_t r;
    logic [31:0]   total;
    if (action) begin
      r.status = err;
      r.coord = '0;
      if (err == gctp_pkg::ST_OK) begin
        total = deg * gctp_pkg::UNITS_PER_DEGREE + frac;
        r.coord = neg ? -total : total;
        if ($signed(r.coord) < lo_coord) lo_coord = $signed(r.coord);
        if ($signed(r.coord) > hi_coord) hi_coord = $signed(r.coord);
      end
      coord_q.push_back(r);
      status_count[err]++;
      clear_parse();
      return;
    end
    if (err != gctp_pkg::ST_OK) return;  // latched error: rest of the string is ignored
    if (ch >= gctp_pkg::CH_0 && ch <= gctp_pkg::CH_9) begin
      take_digit(4'(ch - gctp_pkg::CH_0), lon);
      return;
    end
    case (ch)
      gctp_pkg::CH_N_UP, gctp_pkg::CH_N_LO: take_letter(1'b0, 1'b0, lon);
      gctp_pkg::CH_S_UP, gctp_pkg::CH_S_LO: take_letter(1'b0, 1'b1, lon);
      gctp_pkg::CH_E_UP, gctp_pkg::CH_E_LO: take_letter(1'b1, 1'b0, lon);
      gctp_pkg::CH_W_UP, gctp_pkg::CH_W_LO: take_letter(1'b1, 1'b1, lon);
      gctp_pkg::CH_PLUS, gctp_pkg::CH_MINUS: begin
        if (seen.letter || seen.digit || seen.point) err = gctp_pkg::ST_FORMAT;
        else begin
          seen.sign = 1'b1;
          neg = (ch == gctp_pkg::CH_MINUS);
        end
      end
      gctp_pkg::CH_POINT, gctp_pkg::CH_COMMA: begin
        if (seen.letter || seen.point) err = gctp_pkg::ST_FORMAT;
        else begin
          seen.point = 1'b1;
          in_frac = 1'b1;
          min_mode = 1'b0;
        end
      end
      default: err = gctp_pkg::ST_FORMAT;
    endcase
  endtask

  // ---------------- stimulus building ----------------
  task automatic push_word(input logic action, input logic [7:0] ch, input logic lon);
    text_word_t w;
    w.action = action; w.ch = ch; w.lon = lon; w.drain = drain_next;
    drain_next = 0;
    word_q.push_back(w);
  endtask

  // send the buffered text and close it with an end word
  task automatic flush_text(input logic lon, input bit mixed_lon);
    foreach (text_buf[i])
      push_word(1'b0, text_buf[i], mixed_lon ? 1'($urandom_range(0, 1)) : lon);
    push_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    text_buf.delete();
  endtask

  task automatic directed(input string s, input logic lon);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    flush_text(lon, 0);
  endtask

  task automatic append_num(input int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic append_letter(input logic lon);
    logic axis;
    logic sw;
    logic [7:0] c;
    axis = lon ^ ($urandom_range(0, 9) == 0);
    sw = 1'($urandom_range(0, 1));
    if (axis) c = sw ? gctp_pkg::CH_W_UP : gctp_pkg::CH_E_UP;
    else c = sw ? gctp_pkg::CH_S_UP : gctp_pkg::CH_N_UP;
    if ($urandom_range(0, 1)) c = c | 8'h20;  // lower case
    text_buf.push_back(c);
  endtask

  task automatic build_fix(input logic lon);
    int lim;
    int style;
    int v;
    int n;
    lim = lon ? 180 : 90;
    style = $urandom_range(0, 9);
    if (style != 9) begin
      if (style >= 4 && style <= 7) n = ($urandom_range(0, 7) == 0);
      else n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) text_buf.push_back($urandom_range(0, 1) ? gctp_pkg::CH_MINUS :
                                                           gctp_pkg::CH_PLUS);
      if ($urandom_range(0, 5) == 0) text_buf.push_back(gctp_pkg::CH_0);
      case ($urandom_range(0, 11))
        0:       v = $urandom_range(lim + 1, 999);
        1, 2:    v = lim;
        default: v = $urandom_range(0, lim);
      endcase
      append_num(v);
    end
    if (style <= 3) begin
      text_buf.push_back($urandom_range(0, 1) ? gctp_pkg::CH_POINT : gctp_pkg::CH_COMMA);
      n = $urandom_range(0, 9);
      repeat (n) text_buf.push_back(gctp_pkg::CH_0 + 8'($urandom_range(0, 9)));
    end else if (style != 8) begin
      append_letter(lon);
      case ($urandom_range(0, 7))
        0:          n = 0;
        1, 2, 3:    n = 1;
        4, 5, 6:    n = 2;
        default:    n = 3;
      endcase
      repeat (n) text_buf.push_back(gctp_pkg::CH_0 + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic build_stimulus();
    string marks;
    int    n_strings;
    int    kind;
    int    n;
    logic  lon;
    marks = "+-.,NSEWnsew0";
    n_strings = 0;
    directed("", 1'b0);                 // empty string
    directed("+-9", 1'b0);              // last sign wins
    directed("91", 1'b0);               // over latitude limit
    directed("181X5", 1'b1);            // over longitude limit, then ignored text
    directed("180W99", 1'b1);           // most negative value, minutes unchecked
    directed("90.1234567", 1'b0);       // decimals past the sixth are dropped
    directed("1n123", 1'b0);            // third minute digit
    directed("5E", 1'b0);               // letter of the wrong axis
    push_word(1'b0, 8'h00, 1'b0);       // NUL character
    push_word(1'b1, 8'hff, 1'b0);
    push_word(1'b0, gctp_pkg::CH_0 + 8'd9, 1'b0); // axis flips mid-string
    push_word(1'b0, gctp_pkg::CH_0 + 8'd5, 1'b1);
    push_word(1'b1, 8'h00, 1'b1);
    while (word_q.size() < WORD_TARGET) begin
      n_strings++;
      if (n_strings == 20 || n_strings == 55) drain_next = 1;
      kind = $urandom_range(0, 15);
      lon = 1'($urandom_range(0, 1));
      if (kind == 0) begin
        n = $urandom_range(0, 5);
        repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_fix(lon);
      end
      if (kind == 1 && text_buf.size() > 0)
        text_buf[$urandom_range(0, text_buf.size() - 1)] =
          $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                                 marks[$urandom_range(0, marks.len() - 1)];
      flush_text(lon, kind == 2);
    end
    words_total = word_q.size();
  endtask

  // ---------------- sender ----------------
  text_word_t cur;
  bit         in_fire = 0;
  int         burst_left = 8;
  int         gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (word_q.size() == 0 || (word_q[0].drain && coord_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        cur = word_q.pop_front();
        in_tdata <= cur.ch;
        in_tuser <= {cur.lon, cur.action};
        in_tvalid <= 1'b1;
        if (burst_left > 1) burst_left--;
        else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // ---------------- receiver ----------------
  logic [15:0] stall_mask = '0;
  int          pattern_age = 0;
  int          hold_left = 0;
  bit          long_hold_done = 0;

  always @(negedge clk) begin
    if (!long_hold_done && results_seen >= 40) begin
      hold_left = LONG_HOLD;
      long_hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = '0;
          1:       stall_mask = 16'($urandom);
          2:       stall_mask = 16'($urandom & $urandom);
          default: stall_mask = 16'($urandom | $urandom);
        endcase
        pattern_age = 48;
      end
      pattern_age--;
      stall_mask = {stall_mask[0], stall_mask[15:1]};
      out_tready <= !stall_mask[0];
    end
  end

  // ---------------- monitor and watchdog ----------------
  coord_result_t oldest;
  bit            out_fire;
  int            idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire = 0;
    end else begin
      in_fire = in_tvalid && in_tready;
      out_fire = out_tvalid && out_tready;
      if (out_fire) begin
        results_seen++;
        if (coord_q.size() == 0) begin
          $error("unexpected result word: status %0d coordinate %0d",
                 out_tuser, $signed(out_tdata));
          fail_count++;
        end else begin
          oldest = coord_q.pop_front();
          if (out_tuser !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_tuser);
            fail_count++;
          end
          if (out_tdata !== oldest.coord) begin
            $error("coordinate: expected %0d, got %0d",
                   $signed(oldest.coord), $signed(out_tdata));
            fail_count++;
          end
        end
      end
      // predict after checking so a new expectation never pairs with a stray word
      if (in_fire) begin
        words_taken++;
        parse_word(in_tuser[0], in_tdata, in_tuser[1]);
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d idle cycles, %0d results outstanding", idle_cycles,
                 coord_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (words_taken == words_total);
    wait (coord_q.size() == 0);
    repeat (8) @(posedge clk);
    $display("%0d words, %0d strings: ok %0d, format %0d, minutes %0d, lat %0d, lon %0d",
             words_total, results_seen, status_count[gctp_pkg::ST_OK],
             status_count[gctp_pkg::ST_FORMAT], status_count[gctp_pkg::ST_MINUTES],
             status_count[gctp_pkg::ST_LAT], status_count[gctp_pkg::ST_LON]);
    $display("valid coordinates spanned %0d to %0d; %0d mismatches", lo_coord, hi_coord,
             fail_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gctp_pkg.sv
hw/rtl/geo_coordinate_text_parser.sv
bench/testbench.sv
